// File: rtl/gbc_pkg.sv
`default_nettype none

package gbc_pkg;

    localparam int CFG_W   = 16;
    localparam int LIMIT_W = 15;
    localparam int TS_W    = 32;
    localparam int ANG_W   = 16;
    localparam int IDX_W   = 3;

    // register map
    localparam logic [IDX_W-1:0] REG_BASE_X     = 3'd0;
    localparam logic [IDX_W-1:0] REG_BASE_Y     = 3'd1;
    localparam logic [IDX_W-1:0] REG_BASE_Z     = 3'd2;
    localparam logic [IDX_W-1:0] REG_PITCH_LIM  = 3'd3;
    localparam logic [IDX_W-1:0] REG_RATE_LIM   = 3'd4;
    localparam logic [IDX_W-1:0] REG_DEADBAND   = 3'd5;
    localparam logic [IDX_W-1:0] REG_BOOT_WIN   = 3'd6;
    localparam logic [IDX_W-1:0] REG_AVG_WIN    = 3'd7;

    localparam logic [LIMIT_W-1:0] PITCH_LIM_RST = 15'd128;
    localparam logic [LIMIT_W-1:0] RATE_LIM_RST  = 15'd320;
    localparam logic [LIMIT_W-1:0] DEADBAND_RST  = 15'd1638;
    localparam logic [CFG_W-1:0]   BOOT_WIN_RST  = 16'd1000;
    localparam logic [CFG_W-1:0]   AVG_WIN_RST   = 16'd500;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_ACCUM,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_DONE
    } gbc_state_t;

    // exact magnitude of a 16-bit signed value
    function automatic logic [ANG_W:0] mag16(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W:0] ext;
        ext = (ANG_W+1)'(v);
        mag16 = ext[ANG_W] ? (~ext + 1'b1) : ext;
    endfunction

endpackage

`default_nettype wire

// File: rtl/gbc_div.sv
`default_nettype none

module gbc_div
    import gbc_pkg::*;
#(
    parameter int NW = 28,
    parameter int DW = 12
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quot
);

    localparam int SCW = $clog2(NW);

    logic           busy_reg;
    logic           done_reg;
    logic [SCW-1:0] step_reg;
    logic [NW-1:0]  acc_reg;
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  den_reg;

    logic [DW:0]    rem_sh;
    logic [DW+1:0]  diff;
    logic           borrow;

    // one restoring step: shift in the next dividend bit, try the subtract
    always_comb
    begin
        rem_sh = {rem_reg, acc_reg[NW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, den_reg};
        borrow = diff[DW+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == SCW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[NW-2:0], ~borrow};
            rem_reg <= borrow ? rem_sh[DW-1:0] : diff[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = acc_reg;

endmodule

`default_nettype wire

// File: rtl/gyro_bias_calibrator_core.sv
// Gyro bias calibrator.
// Input channel (in_valid/in_ready) takes one beat per IMU sample: timestamp, three raw
// gyro rates, pitch, joystick position and a recalibration request. Output channel
// (out_valid/out_ready) returns one beat per sample: the three rates with the running
// bias removed and saturated, the running bias itself, and the update/save flags.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register per cycle;
// write it only while no sample is in flight.
// A sample that closes no averaging window passes through S_EVAL, S_ACCUM and S_DONE
// before out_valid rises. A sample that closes a window runs one shared restoring
// divider three times, once per axis, between S_ACCUM and S_DONE; its dividend is
// NW = SAMPLE_WIDTH + clog2(MAX_SAMPLES + 1) + 1 bits wide. One sample is processed
// at a time; in_ready is low until the result has moved to the output register.
// A result waiting on a stalled receiver sits in the output register, and the next
// sample is already accepted and worked on; that sample then holds until the output
// register frees up.
// Reset clears the calibration state and loads the register reset values; the running
// bias is loaded from the base registers on the first sample after reset.
`default_nettype none

module gyro_bias_calibrator_core
    import gbc_pkg::*;
#(
    parameter int MAX_SAMPLES  = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_we,
    input  wire logic [IDX_W-1:0]               cfg_index,
    input  wire logic [CFG_W-1:0]               cfg_data,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [TS_W-1:0]                timestamp_ms,
    input  wire logic signed [SAMPLE_WIDTH-1:0] gyro_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] gyro_y,
    input  wire logic signed [SAMPLE_WIDTH-1:0] gyro_z,
    input  wire logic signed [ANG_W-1:0]        pitch,
    input  wire logic signed [ANG_W-1:0]        joy_x,
    input  wire logic signed [ANG_W-1:0]        joy_y,
    input  wire logic                           recal_request,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      corrected_x,
    output logic signed [SAMPLE_WIDTH-1:0]      corrected_y,
    output logic signed [SAMPLE_WIDTH-1:0]      corrected_z,
    output logic signed [SAMPLE_WIDTH-1:0]      bias_x,
    output logic signed [SAMPLE_WIDTH-1:0]      bias_y,
    output logic signed [SAMPLE_WIDTH-1:0]      bias_z,
    output logic                                bias_updated,
    output logic                                base_saved
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int SUMW = SW + CW;
    localparam int NW   = SUMW + 1;
    localparam int DW   = CW + 1;
    localparam int BW   = (SW > CFG_W) ? SW : CFG_W;
    localparam int YMW  = (SW + 1 > LIMIT_W) ? SW + 1 : LIMIT_W;
    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    // configuration
    logic signed [CFG_W-1:0] base_reg [3];
    logic [LIMIT_W-1:0]      pitch_lim_reg;
    logic [LIMIT_W-1:0]      rate_lim_reg;
    logic [LIMIT_W-1:0]      deadband_reg;
    logic [CFG_W-1:0]        boot_win_reg;
    logic [CFG_W-1:0]        avg_win_reg;

    // latched sample
    logic [TS_W-1:0]         ts_reg;
    logic signed [SW-1:0]    g_reg [3];
    logic signed [ANG_W-1:0] pitch_reg;
    logic signed [ANG_W-1:0] jx_reg;
    logic signed [ANG_W-1:0] jy_reg;
    logic                    req_reg;

    // calibration state
    gbc_state_t              state_reg, state_next;
    logic                    started_reg;
    logic [TS_W-1:0]         boot_time_reg;
    logic                    pending_reg;
    logic                    open_reg;
    logic [TS_W-1:0]         start_reg;
    logic [CW-1:0]           cnt_reg;
    logic signed [SUMW-1:0]  sums_reg [3];
    logic signed [BW-1:0]    bias_reg [3];
    logic [1:0]              axis_reg;
    logic                    wq_reg;
    logic                    updated_reg;
    logic                    saved_reg;

    // output register
    logic                    out_valid_reg;
    logic signed [SW-1:0]    corr_out_reg [3];
    logic signed [SW-1:0]    bias_out_reg [3];
    logic                    upd_out_reg;
    logic                    saved_out_reg;

    logic                    in_fire;
    logic                    out_load;
    logic                    div_start;
    logic                    div_done;
    logic [NW-1:0]           div_quot;
    logic [NW-1:0]           div_num;
    logic [DW-1:0]           div_den;

    logic [TS_W-1:0]         boot_eff;
    logic                    want;
    logic                    quiet;
    logic signed [SW:0]      gy_ext;
    logic [SW:0]             gy_mag;
    logic [TS_W-1:0]         start_eff;
    logic [CW-1:0]           cnt_inc;
    logic                    close_now;
    logic signed [SUMW-1:0]  sum_sel;
    logic [SUMW-1:0]         sum_mag;
    logic signed [NW:0]      quot_s;
    logic signed [SW-1:0]    avg_sat;
    logic signed [SW-1:0]    corr [3];

    function automatic logic signed [SW-1:0] sat_q(input logic signed [NW:0] v);
        if (v > (NW+1)'(S_MAX))
            sat_q = S_MAX;
        else if (v < (NW+1)'(S_MIN))
            sat_q = S_MIN;
        else
            sat_q = $signed(v[SW-1:0]);
    endfunction

    function automatic logic signed [SW-1:0] sat_c(input logic signed [BW:0] v);
        if (v > (BW+1)'(S_MAX))
            sat_c = S_MAX;
        else if (v < (BW+1)'(S_MIN))
            sat_c = S_MIN;
        else
            sat_c = $signed(v[SW-1:0]);
    endfunction

    // ---------------- configuration writes ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg[0]   <= '0;
            base_reg[1]   <= '0;
            base_reg[2]   <= '0;
            pitch_lim_reg <= PITCH_LIM_RST;
            rate_lim_reg  <= RATE_LIM_RST;
            deadband_reg  <= DEADBAND_RST;
            boot_win_reg  <= BOOT_WIN_RST;
            avg_win_reg   <= AVG_WIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_X:    base_reg[0]   <= $signed(cfg_data);
                REG_BASE_Y:    base_reg[1]   <= $signed(cfg_data);
                REG_BASE_Z:    base_reg[2]   <= $signed(cfg_data);
                REG_PITCH_LIM: pitch_lim_reg <= cfg_data[LIMIT_W-1:0];
                REG_RATE_LIM:  rate_lim_reg  <= cfg_data[LIMIT_W-1:0];
                REG_DEADBAND:  deadband_reg  <= cfg_data[LIMIT_W-1:0];
                REG_BOOT_WIN:  boot_win_reg  <= cfg_data;
                REG_AVG_WIN:   avg_win_reg   <= cfg_data;
                default:       avg_win_reg   <= avg_win_reg;
            endcase
        end
    end

    // ---------------- sample qualification ----------------
    always_comb
    begin
        boot_eff = started_reg ? boot_time_reg : ts_reg;
        want     = ((ts_reg - boot_eff) < TS_W'(boot_win_reg)) || pending_reg || req_reg;
        gy_ext   = (SW+1)'(g_reg[1]);
        gy_mag   = gy_ext[SW] ? (~gy_ext + 1'b1) : gy_ext;
        quiet    = (mag16(pitch_reg) < (ANG_W+1)'(pitch_lim_reg))
                && (YMW'(gy_mag) < YMW'(rate_lim_reg))
                && (mag16(jx_reg) < (ANG_W+1)'(deadband_reg))
                && (mag16(jy_reg) < (ANG_W+1)'(deadband_reg));
    end

    // ---------------- window close test ----------------
    always_comb
    begin
        start_eff = open_reg ? start_reg : ts_reg;
        cnt_inc   = cnt_reg + 1'b1;
        close_now = wq_reg && (((ts_reg - start_eff) >= TS_W'(avg_win_reg))
                            || (cnt_inc >= CW'(MAX_SAMPLES)));
    end

    // ---------------- divider operands and result ----------------
    always_comb
    begin
        sum_sel = sums_reg[axis_reg];
        sum_mag = sum_sel[SUMW-1] ? (~sum_sel + 1'b1) : sum_sel;
        // round to nearest, ties away from zero: (2|sum| + n) / 2n
        div_num = {sum_mag, 1'b0} + NW'(cnt_reg);
        div_den = {cnt_reg, 1'b0};
        quot_s  = sum_sel[SUMW-1] ? -$signed((NW+1)'(div_quot)) : $signed((NW+1)'(div_quot));
        avg_sat = sat_q(quot_s);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            corr[i] = sat_c((BW+1)'(g_reg[i]) - (BW+1)'(bias_reg[i]));
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                state_next = close_now ? S_DIV_LOAD : S_DONE;
            end
            S_DIV_LOAD:
            begin
                state_next = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                if (div_done)
                    state_next = (axis_reg == 2'd2) ? S_DONE : S_DIV_LOAD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        div_start = (state_reg == S_DIV_LOAD);
        out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    end

    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // hold the accepted beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ts_reg    <= timestamp_ms;
            g_reg[0]  <= gyro_x;
            g_reg[1]  <= gyro_y;
            g_reg[2]  <= gyro_z;
            pitch_reg <= pitch;
            jx_reg    <= joy_x;
            jy_reg    <= joy_y;
            req_reg   <= recal_request;
        end
    end

    // ---------------- calibration state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            boot_time_reg <= '0;
            pending_reg   <= 1'b0;
            open_reg      <= 1'b0;
            start_reg     <= '0;
            cnt_reg       <= '0;
            sums_reg[0]   <= '0;
            sums_reg[1]   <= '0;
            sums_reg[2]   <= '0;
            bias_reg[0]   <= '0;
            bias_reg[1]   <= '0;
            bias_reg[2]   <= '0;
            axis_reg      <= '0;
            wq_reg        <= 1'b0;
            updated_reg   <= 1'b0;
            saved_reg     <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_EVAL:
                begin
                    started_reg <= 1'b1;
                    if (!started_reg)
                    begin
                        // first sample: start the boot window, take the stored bias
                        boot_time_reg <= ts_reg;
                        for (int i = 0; i < 3; i++)
                        begin
                            bias_reg[i] <= BW'(base_reg[i]);
                        end
                    end
                    pending_reg <= pending_reg || req_reg;
                    wq_reg      <= want && quiet;
                    updated_reg <= 1'b0;
                    saved_reg   <= 1'b0;
                end
                S_ACCUM:
                begin
                    axis_reg <= '0;
                    if (wq_reg)
                    begin
                        open_reg  <= 1'b1;
                        start_reg <= start_eff;
                        cnt_reg   <= cnt_inc;
                        for (int i = 0; i < 3; i++)
                        begin
                            sums_reg[i] <= sums_reg[i] + SUMW'(g_reg[i]);
                        end
                    end
                    else
                    begin
                        // drop the partial window
                        open_reg    <= 1'b0;
                        start_reg   <= '0;
                        cnt_reg     <= '0;
                        sums_reg[0] <= '0;
                        sums_reg[1] <= '0;
                        sums_reg[2] <= '0;
                    end
                end
                S_DIV_RUN:
                begin
                    if (div_done)
                    begin
                        bias_reg[axis_reg] <= BW'(avg_sat);
                        axis_reg           <= axis_reg + 1'b1;
                        if (axis_reg == 2'd2)
                        begin
                            updated_reg <= 1'b1;
                            saved_reg   <= pending_reg;
                            pending_reg <= 1'b0;
                            open_reg    <= 1'b0;
                            start_reg   <= '0;
                            cnt_reg     <= '0;
                            sums_reg[0] <= '0;
                            sums_reg[1] <= '0;
                            sums_reg[2] <= '0;
                        end
                    end
                end
                default:
                begin
                    wq_reg <= wq_reg;
                end
            endcase
        end
    end

    gbc_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                corr_out_reg[i] <= corr[i];
                bias_out_reg[i] <= $signed(bias_reg[i][SW-1:0]);
            end
            upd_out_reg   <= updated_reg;
            saved_out_reg <= saved_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign corrected_x  = corr_out_reg[0];
    assign corrected_y  = corr_out_reg[1];
    assign corrected_z  = corr_out_reg[2];
    assign bias_x       = bias_out_reg[0];
    assign bias_y       = bias_out_reg[1];
    assign bias_z       = bias_out_reg[2];
    assign bias_updated = upd_out_reg;
    assign base_saved   = saved_out_reg;

endmodule

`default_nettype wire

// File: rtl/gbc_checker.sv
`default_nettype none

module gbc_checker
    import gbc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic signed [SAMPLE_WIDTH-1:0] corrected_x,
    input wire logic signed [SAMPLE_WIDTH-1:0] bias_x,
    input wire logic                           bias_updated,
    input wire logic                           base_saved
);

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(corrected_x) && $stable(bias_x)
                                       && $stable(bias_updated) && $stable(base_saved)))
        else $error("output beat changed while stalled");

    // a save only comes with a new bias
    a_save_implies_update: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && base_saved) |-> bias_updated)
        else $error("base_saved without bias_updated");

    // one sample at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while previous sample in flight");

    // no result appears in the cycle right after an accept
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!out_valid || $past(out_valid)))
        else $error("result appeared too early");

endmodule

bind gyro_bias_calibrator_core gbc_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_gbc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .corrected_x  (corrected_x),
    .bias_x       (bias_x),
    .bias_updated (bias_updated),
    .base_saved   (base_saved)
);

`default_nettype wire
